// File: sv/triple_timer_io_registers_core_assert.svh
// Assertion macros used by the checker of the triple timer I/O block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef TRIPLE_TIMER_IO_REGISTERS_CORE_ASSERT_SVH
`define TRIPLE_TIMER_IO_REGISTERS_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is applied.
`define TTIOR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define TTIOR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ttior_pkg.sv
// Types and constants of the triple timer I/O register block.
// No dependencies; used by the core and its checker.
package ttior_pkg;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_WRITE = 2'd2
    } func_t;

    localparam int NUM_TIMERS = 3;
    localparam int NUM_PORTS  = 4;

    localparam logic [3:0] ADDR_TEST      = 4'h0;
    localparam logic [3:0] ADDR_CONTROL   = 4'h1;
    localparam logic [3:0] ADDR_DSP_ADDR  = 4'h2;
    localparam logic [3:0] ADDR_DSP_DATA  = 4'h3;
    localparam logic [3:0] ADDR_PORT0     = 4'h4;
    localparam logic [3:0] ADDR_PORT3     = 4'h7;
    localparam logic [3:0] ADDR_UNUSED0   = 4'h8;
    localparam logic [3:0] ADDR_UNUSED1   = 4'h9;
    localparam logic [3:0] ADDR_TARGET0   = 4'hA;
    localparam logic [3:0] ADDR_TARGET2   = 4'hC;
    localparam logic [3:0] ADDR_COUNTER0  = 4'hD;
    localparam logic [3:0] ADDR_COUNTER2  = 4'hF;

    localparam int CTRL_CLEAR_PORTS_01 = 4;
    localparam int CTRL_CLEAR_PORTS_23 = 5;

    localparam logic [7:0] BYTE_ALL_ONES = 8'hFF;

endpackage

// File: sv/triple_timer_io_registers_core.sv
// Triple timer I/O register block: three timers, four port latches and a
// 16-address register window. Depends on ttior_pkg.
// An accepted request's result is loaded into the output register in the next
// cycle; one request is accepted every cycle, limited only by that register.
// Reset clears all registers, timer stages, the prescaler and the port latches.
module triple_timer_io_registers_core #(
    parameter int PRESCALE_TICKS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,  // addr[3:0], wdata[11:4], zero fill
    input  logic [1:0]            s_tuser,  // func[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,  // rdata[7:0]
    output logic                  m_tuser   // unmapped[0]
);
    import ttior_pkg::*;

    localparam int PS_W = $clog2(PRESCALE_TICKS + 1);

    logic [7:0]      test_reg,     test_next;
    logic [7:0]      control_reg,  control_next;
    logic [7:0]      dsp_addr_reg, dsp_addr_next;
    logic [7:0]      target_reg   [NUM_TIMERS];
    logic [7:0]      target_next  [NUM_TIMERS];
    logic [7:0]      counter_reg  [NUM_TIMERS];
    logic [7:0]      counter_next [NUM_TIMERS];
    logic [7:0]      stage_reg    [NUM_TIMERS];
    logic [7:0]      stage_next   [NUM_TIMERS];
    logic [7:0]      stage_inc    [NUM_TIMERS];
    logic [7:0]      port_reg     [NUM_PORTS];
    logic [7:0]      port_next    [NUM_PORTS];
    logic [PS_W-1:0] prescale_reg, prescale_next, prescale_inc;
    logic            prescale_wrap;
    logic            m_tvalid_reg, m_tvalid_next;
    logic [7:0]      rdata_reg,    rdata_next;
    logic            unmapped_reg, unmapped_next;

    logic            accept;
    func_t           func;
    logic [3:0]      addr;
    logic [7:0]      wdata;
    logic [1:0]      tgt_idx;
    logic [1:0]      cnt_idx;

    assign func     = func_t'(s_tuser);
    assign addr     = s_tdata[3:0];
    assign wdata    = s_tdata[11:4];
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign tgt_idx  = 2'(addr - ADDR_TARGET0);
    assign cnt_idx  = 2'(addr - ADDR_COUNTER0);

    assign prescale_inc  = prescale_reg + PS_W'(1);
    assign prescale_wrap = prescale_inc >= PS_W'(PRESCALE_TICKS);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = rdata_reg;
    assign m_tuser  = unmapped_reg;

    always_comb
    begin
        test_next     = test_reg;
        control_next  = control_reg;
        dsp_addr_next = dsp_addr_reg;
        target_next   = target_reg;
        counter_next  = counter_reg;
        stage_next    = stage_reg;
        port_next     = port_reg;
        prescale_next = prescale_reg;
        rdata_next    = rdata_reg;
        unmapped_next = unmapped_reg;
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;

        for (int t = 0; t < NUM_TIMERS; t++)
        begin
            stage_inc[t] = stage_reg[t] + 8'd1;
        end

        if (accept)
        begin
            m_tvalid_next = 1'b1;
            rdata_next    = '0;
            unmapped_next = 1'b0;
            case (func)
                FUNC_TICK:
                begin
                    prescale_next = prescale_wrap ? '0 : prescale_inc;
                    for (int t = 0; t < NUM_TIMERS; t++)
                    begin
                        if (t == NUM_TIMERS - 1 || prescale_wrap)
                        begin
                            if (stage_inc[t] == target_reg[t])
                            begin
                                stage_next[t] = '0;
                                if (control_reg[t])
                                begin
                                    counter_next[t] = {4'd0, counter_reg[t][3:0] + 4'd1};
                                end
                            end
                            else
                            begin
                                stage_next[t] = stage_inc[t];
                            end
                        end
                    end
                end
                FUNC_READ:
                begin
                    case (addr) inside
                        ADDR_TEST:                    rdata_next = test_reg;
                        ADDR_CONTROL:                 rdata_next = control_reg;
                        ADDR_DSP_ADDR:                rdata_next = dsp_addr_reg;
                        [ADDR_PORT0:ADDR_PORT3]:      rdata_next = port_reg[addr[1:0]];
                        [ADDR_TARGET0:ADDR_TARGET2]:  rdata_next = target_reg[tgt_idx];
                        [ADDR_COUNTER0:ADDR_COUNTER2]: rdata_next = counter_reg[cnt_idx];
                        ADDR_DSP_DATA:                rdata_next = BYTE_ALL_ONES;
                        ADDR_UNUSED0, ADDR_UNUSED1:
                        begin
                            rdata_next    = BYTE_ALL_ONES;
                            unmapped_next = 1'b1;
                        end
                        default:                      rdata_next = BYTE_ALL_ONES;
                    endcase
                end
                FUNC_WRITE:
                begin
                    case (addr) inside
                        ADDR_TEST:                    test_next = wdata;
                        ADDR_CONTROL:
                        begin
                            control_next = wdata;
                            if (wdata[CTRL_CLEAR_PORTS_23])
                            begin
                                port_next[2] = '0;
                                port_next[3] = '0;
                            end
                            if (wdata[CTRL_CLEAR_PORTS_01])
                            begin
                                port_next[0] = '0;
                                port_next[1] = '0;
                            end
                        end
                        ADDR_DSP_ADDR:                dsp_addr_next = wdata;
                        [ADDR_PORT0:ADDR_PORT3]:      port_next[addr[1:0]] = wdata;
                        [ADDR_TARGET0:ADDR_TARGET2]:  target_next[tgt_idx] = wdata;
                        [ADDR_COUNTER0:ADDR_COUNTER2]: counter_next[cnt_idx] = wdata;
                        ADDR_UNUSED0, ADDR_UNUSED1:   unmapped_next = 1'b1;
                        default:                      ;
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            test_reg     <= '0;
            control_reg  <= '0;
            dsp_addr_reg <= '0;
            for (int t = 0; t < NUM_TIMERS; t++)
            begin
                target_reg[t]  <= '0;
                counter_reg[t] <= '0;
                stage_reg[t]   <= '0;
            end
            for (int p = 0; p < NUM_PORTS; p++)
            begin
                port_reg[p] <= '0;
            end
            prescale_reg <= '0;
            m_tvalid_reg <= 1'b0;
            rdata_reg    <= '0;
            unmapped_reg <= 1'b0;
        end
        else
        begin
            test_reg     <= test_next;
            control_reg  <= control_next;
            dsp_addr_reg <= dsp_addr_next;
            target_reg   <= target_next;
            counter_reg  <= counter_next;
            stage_reg    <= stage_next;
            port_reg     <= port_next;
            prescale_reg <= prescale_next;
            m_tvalid_reg <= m_tvalid_next;
            rdata_reg    <= rdata_next;
            unmapped_reg <= unmapped_next;
        end
    end

endmodule

// File: sv/ttior_checker.sv
// Port-level checker for the triple timer I/O block and its bind statement.
// Depends on ttior_pkg and triple_timer_io_registers_core_assert.svh.
`include "triple_timer_io_registers_core_assert.svh"

module ttior_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tuser
);
    import ttior_pkg::*;

    logic s_accept;

    assign s_accept = s_tvalid && s_tready;

    `TTIOR_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `TTIOR_ASSERT_NEXT(a_result_follows, s_accept, m_tvalid, "accepted request gave no result")
    `TTIOR_ASSERT_NEXT(a_zero_unless_read, s_accept && s_tuser != FUNC_READ, m_tdata == 8'h00, "tick or write returned nonzero data")
    `TTIOR_ASSERT_NEXT(a_data_port_read, s_accept && s_tuser == FUNC_READ && s_tdata[3:0] == ADDR_DSP_DATA, m_tdata == BYTE_ALL_ONES && !m_tuser, "data port read wrong")
    `TTIOR_ASSERT_NEXT(a_unmapped_addr, s_accept && s_tdata[3:0] != ADDR_UNUSED0 && s_tdata[3:0] != ADDR_UNUSED1, !m_tuser, "unmapped flag on a handled address")

endmodule

bind triple_timer_io_registers_core ttior_checker u_ttior_checker (.*);

// File: sim/triple_timer_io_registers_core_test.sv
// Self-checking testbench for triple_timer_io_registers_core: directed table, then random
// register traffic and timer ticks with random idling, checked against an in-bench predictor.
// Depends on ttior_pkg and the core RTL only.
module triple_timer_io_registers_core_test;

    import ttior_pkg::*;

    localparam int         PRESCALE_TICKS    = 8;
    localparam int         RANDOM_REQUESTS   = 2000;
    localparam int         ZERO_TARGET_TICKS = 600;
    localparam int         WATCHDOG_LIMIT    = 2000;
    localparam int         DRAIN_CYCLES      = 4;
    localparam int         NUM_DIRECTED      = 25;
    localparam int         TIMER2            = 2;
    localparam logic [1:0] FUNC_UNUSED       = 2'd3;

    typedef struct packed {
        logic [7:0] rdata;
        logic       unmapped;
    } io_response_t;

    typedef struct packed {
        logic [1:0] func;
        logic [3:0] addr;
        logic [7:0] wdata;
        logic       fixed;
        logic [7:0] rdata;
        logic       unmapped;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tuser;

    logic [7:0]   shadow_regs [16];
    logic [7:0]   shadow_stage [3];
    int           shadow_prescale;
    logic [7:0]   shadow_ports [4];
    io_response_t response_queue [$];

    bit steady_flow;
    int mismatch_count;
    int useful_requests;
    int tick_count;
    int read_count;
    int write_count;
    int other_count;
    int responses_checked;

    stim_row_t directed_rows [NUM_DIRECTED] = '{
        '{FUNC_READ,   ADDR_TEST,          8'h00, 1'b1, 8'h00,         1'b0},
        '{FUNC_READ,   ADDR_COUNTER2,      8'hFF, 1'b1, 8'h00,         1'b0},
        '{FUNC_READ,   ADDR_PORT3,         8'h00, 1'b1, 8'h00,         1'b0},
        '{FUNC_READ,   ADDR_DSP_DATA,      8'h00, 1'b1, BYTE_ALL_ONES, 1'b0},
        '{FUNC_READ,   ADDR_UNUSED0,       8'h00, 1'b1, BYTE_ALL_ONES, 1'b1},
        '{FUNC_READ,   ADDR_UNUSED1,       8'h00, 1'b1, BYTE_ALL_ONES, 1'b1},
        '{FUNC_WRITE,  ADDR_UNUSED0,       8'hFF, 1'b1, 8'h00,         1'b1},
        '{FUNC_WRITE,  ADDR_UNUSED1,       8'h00, 1'b1, 8'h00,         1'b1},
        '{FUNC_WRITE,  ADDR_DSP_DATA,      8'hFF, 1'b1, 8'h00,         1'b0},
        '{FUNC_UNUSED, ADDR_COUNTER2,      8'hFF, 1'b1, 8'h00,         1'b0},
        '{FUNC_WRITE,  ADDR_PORT0,         8'hFF, 1'b1, 8'h00,         1'b0},
        '{FUNC_WRITE,  ADDR_PORT3,         8'h5A, 1'b1, 8'h00,         1'b0},
        '{FUNC_WRITE,  ADDR_CONTROL,       8'h10, 1'b1, 8'h00,         1'b0},
        '{FUNC_READ,   ADDR_PORT0,         8'h00, 1'b0, 8'h00,         1'b0},
        '{FUNC_READ,   ADDR_PORT3,         8'h00, 1'b0, 8'h00,         1'b0},
        '{FUNC_WRITE,  ADDR_CONTROL,       8'h27, 1'b1, 8'h00,         1'b0},
        '{FUNC_READ,   ADDR_PORT3,         8'h00, 1'b0, 8'h00,         1'b0},
        '{FUNC_WRITE,  ADDR_TARGET2,       8'h01, 1'b1, 8'h00,         1'b0},
        '{FUNC_WRITE,  ADDR_COUNTER2,      8'hFF, 1'b1, 8'h00,         1'b0},
        '{FUNC_TICK,   ADDR_TEST,          8'h00, 1'b1, 8'h00,         1'b0},
        '{FUNC_READ,   ADDR_COUNTER2,      8'h00, 1'b0, 8'h00,         1'b0},
        '{FUNC_WRITE,  ADDR_TEST,          8'hFF, 1'b1, 8'h00,         1'b0},
        '{FUNC_READ,   ADDR_TEST,          8'h00, 1'b0, 8'h00,         1'b0},
        '{FUNC_WRITE,  ADDR_DSP_ADDR,      8'h80, 1'b1, 8'h00,         1'b0},
        '{FUNC_READ,   ADDR_DSP_ADDR,      8'h00, 1'b0, 8'h00,         1'b0}
    };

    triple_timer_io_registers_core #(
        .PRESCALE_TICKS(PRESCALE_TICKS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void advance_stage(int t);
        logic [7:0] target;
        target = shadow_regs[ADDR_TARGET0 + t];
        shadow_stage[t] = shadow_stage[t] + 8'd1;
        if (shadow_stage[t] == target)
        begin
            shadow_stage[t] = 8'd0;
            if (shadow_regs[ADDR_CONTROL][t])
                shadow_regs[ADDR_COUNTER0 + t] = (shadow_regs[ADDR_COUNTER0 + t] + 8'd1) & 8'h0F;
        end
    endfunction

    function automatic io_response_t apply_request(logic [1:0] func, logic [3:0] addr,
                                                   logic [7:0] wdata);
        io_response_t resp;
        bit           stored;
        bit           is_port;
        resp    = '0;
        stored  = (addr <= ADDR_DSP_ADDR) || (addr >= ADDR_TARGET0);
        is_port = (addr >= ADDR_PORT0) && (addr <= ADDR_PORT3);
        case (func)
            FUNC_TICK:
            begin
                advance_stage(TIMER2);
                shadow_prescale++;
                if (shadow_prescale >= PRESCALE_TICKS)
                begin
                    advance_stage(0);
                    advance_stage(1);
                    shadow_prescale = 0;
                end
            end
            FUNC_READ:
            begin
                if (stored)
                    resp.rdata = shadow_regs[addr];
                else if (is_port)
                    resp.rdata = shadow_ports[addr[1:0]];
                else if (addr == ADDR_DSP_DATA)
                    resp.rdata = BYTE_ALL_ONES;
                else
                begin
                    resp.rdata    = BYTE_ALL_ONES;
                    resp.unmapped = 1'b1;
                end
            end
            FUNC_WRITE:
            begin
                if (addr == ADDR_CONTROL)
                begin
                    if (wdata[CTRL_CLEAR_PORTS_23])
                    begin
                        shadow_ports[2] = 8'd0;
                        shadow_ports[3] = 8'd0;
                    end
                    if (wdata[CTRL_CLEAR_PORTS_01])
                    begin
                        shadow_ports[0] = 8'd0;
                        shadow_ports[1] = 8'd0;
                    end
                    shadow_regs[ADDR_CONTROL] = wdata;
                end
                else if (stored)
                    shadow_regs[addr] = wdata;
                else if (is_port)
                    shadow_ports[addr[1:0]] = wdata;
                else if (addr != ADDR_DSP_DATA)
                    resp.unmapped = 1'b1;
            end
            default:
            begin
            end
        endcase
        return resp;
    endfunction

    task automatic send_request(logic [1:0] func, logic [3:0] addr, logic [7:0] wdata,
                                bit fixed, io_response_t fixed_resp);
        int           gap;
        io_response_t predicted;
        gap = steady_flow ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {4'h0, wdata, addr};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = apply_request(func, addr, wdata);
        response_queue.push_back(fixed ? fixed_resp : predicted);
        case (func)
            FUNC_TICK:  tick_count++;
            FUNC_READ:  read_count++;
            FUNC_WRITE: write_count++;
            default:    other_count++;
        endcase
        if (!(func == FUNC_UNUSED || (func == FUNC_WRITE &&
              (addr == ADDR_DSP_DATA || addr == ADDR_UNUSED0 || addr == ADDR_UNUSED1))))
            useful_requests++;
    endtask

    task automatic send_checked(logic [1:0] func, logic [3:0] addr, logic [7:0] wdata);
        send_request(func, addr, wdata, 1'b0, '0);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (response_queue.size() != 0);
    endtask

    function automatic logic [7:0] pick_target();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return 8'h00;
        else if (pick == 1)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(1, 6));
    endfunction

    task automatic timer_segment();
        int         count;
        int         pick;
        logic [3:0] addr;
        send_checked(FUNC_WRITE, ADDR_TARGET0 + 4'($urandom_range(0, 2)), pick_target());
        send_checked(FUNC_WRITE, ADDR_CONTROL, 8'($urandom_range(0, 255)));
        count = $urandom_range(20, 60);
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            addr = 4'($urandom_range(0, 15));
            if (pick < 55)
                send_checked(FUNC_TICK, addr, 8'($urandom_range(0, 255)));
            else if (pick < 70)
                send_checked(FUNC_READ, ADDR_COUNTER0 + 4'($urandom_range(0, 2)),
                             8'($urandom_range(0, 255)));
            else if (pick < 82)
                send_checked(FUNC_READ, addr, 8'($urandom_range(0, 255)));
            else if (pick < 92)
                send_checked(FUNC_WRITE, ADDR_PORT0 + 4'($urandom_range(0, 3)),
                             8'($urandom_range(0, 255)));
            else if (pick < 96)
                send_checked(FUNC_WRITE, ADDR_COUNTER0 + 4'($urandom_range(0, 2)),
                             8'($urandom_range(0, 255)));
            else
                send_checked(FUNC_WRITE, addr, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic noise_segment();
        repeat (8)
            send_checked(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                         8'($urandom_range(0, 255)));
    endtask

    task automatic zero_target_burst();
        logic [7:0] ctrl;
        ctrl         = 8'($urandom_range(0, 255));
        ctrl[TIMER2] = 1'b1;
        send_checked(FUNC_WRITE, ADDR_TARGET2, 8'h00);
        send_checked(FUNC_WRITE, ADDR_CONTROL, ctrl);
        repeat (ZERO_TARGET_TICKS)
            send_checked(FUNC_TICK, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
        send_checked(FUNC_READ, ADDR_COUNTER2, 8'h00);
    endtask

    initial
    begin
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            int           stall;
            io_response_t got;
            io_response_t want;
            stall = steady_flow ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            got = '{m_tdata, m_tuser};
            if (response_queue.size() == 0)
            begin
                $error("Unexpected response: rdata %0h, unmapped %0b", got.rdata, got.unmapped);
                mismatch_count++;
            end
            else
            begin
                want = response_queue.pop_front();
                responses_checked++;
                if (got.rdata !== want.rdata)
                begin
                    $error("rdata: expected %0h, actual %0h", want.rdata, got.rdata);
                    mismatch_count++;
                end
                if (got.unmapped !== want.unmapped)
                begin
                    $error("unmapped: expected %0b, actual %0b", want.unmapped, got.unmapped);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        wait (rst_n);
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timeout after %0d cycles without a transfer", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        bit burst_done;
        clk      = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        foreach (shadow_regs[i])
            shadow_regs[i] = 8'd0;
        foreach (shadow_stage[i])
            shadow_stage[i] = 8'd0;
        foreach (shadow_ports[i])
            shadow_ports[i] = 8'd0;
        shadow_prescale = 0;
        burst_done      = 1'b0;
        steady_flow     = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].func, directed_rows[i].addr, directed_rows[i].wdata,
                         directed_rows[i].fixed,
                         '{directed_rows[i].rdata, directed_rows[i].unmapped});
        drain_results();

        while (useful_requests < NUM_DIRECTED + RANDOM_REQUESTS)
        begin
            if (!burst_done && useful_requests >= NUM_DIRECTED + RANDOM_REQUESTS / 2)
            begin
                drain_results();
                zero_target_burst();
                burst_done = 1'b1;
            end
            steady_flow = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0)
                noise_segment();
            else
                timer_segment();
        end
        steady_flow = 1'b0;

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (response_queue.size() != 0)
        begin
            $error("%0d expected responses never arrived", response_queue.size());
            mismatch_count++;
        end

        $display("Covered %0d ticks, %0d reads, %0d writes, %0d unused-function requests;",
                 tick_count, read_count, write_count, other_count);
        $display("%0d responses compared, including a timer 2 run with a zero target.",
                 responses_checked);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
